// ----- sv/qau_pkg.sv -----
// Shared types, widths, opcodes and saturation helpers for the quaternion unit.
// No dependencies; every other file imports this package.
`default_nettype none

package qau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;              // data word
  localparam int OW        = DW + 1;          // operand with differences
  localparam int PW        = 2 * OW;          // product of two operands
  localparam int SW        = PW + 2;          // sum of four products
  localparam int SSQ_W     = 2 * DW + 1;      // sum of squares, up to 2**64
  localparam int RB        = DW + 1;          // root bits, root up to 2**32
  localparam int RT_W      = SSQ_W + 2;       // square root working width
  localparam int QB        = DW + 1;          // quotient bits below overflow
  localparam int NUM_W     = (2 * FRAC_BITS + DW + 2 > SSQ_W + 2) ?
                             (2 * FRAC_BITS + DW + 2) : (SSQ_W + 2);
  localparam int DEN_W     = SSQ_W + 1;

  localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_PROD = 4'd2;
  localparam logic [3:0] OP_CONJ = 4'd3;
  localparam logic [3:0] OP_MAG  = 4'd4;
  localparam logic [3:0] OP_NORM = 4'd5;
  localparam logic [3:0] OP_INV  = 4'd6;
  localparam logic [3:0] OP_DOT  = 4'd7;
  localparam logic [3:0] OP_DIST = 4'd8;
  localparam logic [3:0] OP_CHEB = 4'd9;

  typedef struct packed {
    logic        [3:0]    cmd;
    logic signed [DW-1:0] x_real;
    logic signed [DW-1:0] x_i;
    logic signed [DW-1:0] x_j;
    logic signed [DW-1:0] x_k;
    logic signed [DW-1:0] y_real;
    logic signed [DW-1:0] y_i;
    logic signed [DW-1:0] y_j;
    logic signed [DW-1:0] y_k;
  } qau_in_t;

  typedef struct packed {
    logic signed [DW-1:0] r_real;
    logic signed [DW-1:0] r_i;
    logic signed [DW-1:0] r_j;
    logic signed [DW-1:0] r_k;
    logic signed [DW-1:0] scalar_out;
    logic                 zero_div;
    logic                 saturated;
  } qau_out_t;

  // Per-item sideband that rides along the pipeline
  typedef struct packed {
    logic [3:0]          cmd;
    logic [3:0][DW-1:0]  rq;
    logic [DW-1:0]       sc;
    logic                zd;
    logic                sat;
    logic [3:0][DW-1:0]  mag;
    logic [3:0]          neg;
    logic                big;
  } qau_side_t;

  // Clip a wide signed value to DW bits; top bit of the result is the clip flag
  function automatic logic [DW:0] clip_wide(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    logic [DW:0]          r;
    hi = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    if (v > hi) begin
      r = {1'b1, POS_MAX};
    end else if (v < lo) begin
      r = {1'b1, NEG_MIN};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  // Apply a sign to a magnitude and clip; top bit of the result is the clip flag
  function automatic logic [DW:0] from_mag(input logic neg, input logic [QB:0] m);
    logic [QB:0] pos_lim;
    logic [QB:0] neg_lim;
    logic [QB:0] mn;
    logic [DW:0] r;
    pos_lim = {{(QB+2-DW){1'b0}}, {(DW-1){1'b1}}};
    neg_lim = {{(QB+1-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
    mn      = (~m) + 1'b1;
    if (!neg) begin
      r = (m > pos_lim) ? {1'b1, POS_MAX} : {1'b0, m[DW-1:0]};
    end else begin
      r = (m > neg_lim) ? {1'b1, NEG_MIN} : {1'b0, mn[DW-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/qau_front.sv -----
// Front end: operand selection, sixteen multipliers, sums and rounding.
// Depends on qau_pkg; five register stages.
`default_nettype none

module qau_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  qau_pkg::qau_in_t   in_item,
  output logic               out_valid,
  output qau_pkg::qau_side_t side,
  output logic [qau_pkg::SSQ_W-1:0] ssq
);
  import qau_pkg::*;

  localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // stage 1: registered input
  logic    v1;
  qau_in_t it1;

  logic signed [DW-1:0] x [4];
  logic signed [DW-1:0] y [4];
  logic signed [OW-1:0] dif [4];
  logic signed [OW-1:0] sum1 [4];
  logic signed [OW-1:0] negx [4];
  logic        [OW-1:0] absd1 [4];
  logic signed [OW-1:0] ma1 [4][4];
  logic signed [OW-1:0] mb1 [4][4];
  qau_side_t            sd1;
  logic        [DW:0]   cl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      it1 <= in_item;
    end
  end

  always_comb begin
    x[0] = it1.x_real; x[1] = it1.x_i; x[2] = it1.x_j; x[3] = it1.x_k;
    y[0] = it1.y_real; y[1] = it1.y_i; y[2] = it1.y_j; y[3] = it1.y_k;
    sd1     = '0;
    sd1.cmd = it1.cmd;
    cl      = '0;
    for (int n = 0; n < 4; n++) begin
      dif[n]  = {x[n][DW-1], x[n]} - {y[n][DW-1], y[n]};
      sum1[n] = {x[n][DW-1], x[n]} + {y[n][DW-1], y[n]};
      negx[n] = {OW{1'b0}} - {x[n][DW-1], x[n]};
      absd1[n] = dif[n][OW-1] ? ((~dif[n]) + 1'b1) : dif[n];
      sd1.mag[n] = x[n][DW-1] ? ((~x[n]) + 1'b1) : x[n];
      sd1.neg[n] = x[n][DW-1];
      if (absd1[n][OW-1] || absd1[n][OW-2]) begin
        sd1.big = 1'b1;
      end
    end
    case (it1.cmd)
      OP_ADD: begin
        for (int n = 0; n < 4; n++) begin
          cl = clip_wide({{(SW-OW){sum1[n][OW-1]}}, sum1[n]});
          sd1.rq[n] = cl[DW-1:0];
          sd1.sat   = sd1.sat | cl[DW];
        end
      end
      OP_SUB: begin
        for (int n = 0; n < 4; n++) begin
          cl = clip_wide({{(SW-OW){dif[n][OW-1]}}, dif[n]});
          sd1.rq[n] = cl[DW-1:0];
          sd1.sat   = sd1.sat | cl[DW];
        end
      end
      OP_CONJ: begin
        sd1.rq[0] = x[0];
        for (int n = 1; n < 4; n++) begin
          cl = clip_wide({{(SW-OW){negx[n][OW-1]}}, negx[n]});
          sd1.rq[n] = cl[DW-1:0];
          sd1.sat   = sd1.sat | cl[DW];
        end
      end
      default: ;
    endcase
    // diagonal multipliers double as squarers
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        ma1[a][b] = {x[a][DW-1], x[a]};
        mb1[a][b] = {y[b][DW-1], y[b]};
        if (a == b) begin
          if (it1.cmd inside {OP_MAG, OP_NORM, OP_INV}) begin
            mb1[a][b] = {x[a][DW-1], x[a]};
          end else if (it1.cmd == OP_DIST) begin
            ma1[a][b] = dif[a];
            mb1[a][b] = dif[a];
          end
        end
      end
    end
  end

  // stage 2: operands
  logic                 v2;
  qau_side_t            sd2;
  logic        [OW-1:0] absd2 [4];
  logic signed [OW-1:0] ma2 [4][4];
  logic signed [OW-1:0] mb2 [4][4];
  logic signed [PW-1:0] p2 [4][4];
  logic        [OW-1:0] mx01;
  logic        [OW-1:0] mx23;
  logic        [OW-1:0] cheb2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      sd2   <= sd1;
      absd2 <= absd1;
      ma2   <= ma1;
      mb2   <= mb1;
    end
  end

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        p2[a][b] = ma2[a][b] * mb2[a][b];
      end
    end
    mx01  = (absd2[0] > absd2[1]) ? absd2[0] : absd2[1];
    mx23  = (absd2[2] > absd2[3]) ? absd2[2] : absd2[3];
    cheb2 = (mx01 > mx23) ? mx01 : mx23;
  end

  // stage 3: products
  logic                 v3;
  qau_side_t            sd3;
  logic signed [PW-1:0] p3 [4][4];
  logic        [OW-1:0] cheb3;
  logic signed [SW-1:0] e [4][4];
  logic signed [SW-1:0] qs3 [4];
  logic signed [SW-1:0] ds3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      sd3   <= sd2;
      p3    <= p2;
      cheb3 <= cheb2;
    end
  end

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        e[a][b] = {{(SW-PW){p3[a][b][PW-1]}}, p3[a][b]};
      end
    end
    qs3[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
    qs3[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
    qs3[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
    qs3[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
    ds3    = e[0][0] + e[1][1] + e[2][2] + e[3][3];
  end

  // stage 4: sums, then round half up and clip
  logic                 v4;
  qau_side_t            sd4;
  logic signed [SW-1:0] qs4 [4];
  logic signed [SW-1:0] ds4;
  logic        [OW-1:0] cheb4;
  logic signed [SW-1:0] t;
  qau_side_t            sd5;
  logic        [DW:0]   rc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      sd4   <= sd3;
      qs4   <= qs3;
      ds4   <= ds3;
      cheb4 <= cheb3;
    end
  end

  always_comb begin
    sd5 = sd4;
    rc  = '0;
    t   = '0;
    case (sd4.cmd)
      OP_PROD: begin
        for (int n = 0; n < 4; n++) begin
          t  = (qs4[n] + HALF) >>> FRAC_BITS;
          rc = clip_wide(t);
          sd5.rq[n] = rc[DW-1:0];
          sd5.sat   = sd5.sat | rc[DW];
        end
      end
      OP_DOT: begin
        t  = (ds4 + HALF) >>> FRAC_BITS;
        rc = clip_wide(t);
        sd5.sc  = rc[DW-1:0];
        sd5.sat = rc[DW];
      end
      OP_CHEB: begin
        rc = from_mag(1'b0, {1'b0, cheb4});
        sd5.sc  = rc[DW-1:0];
        sd5.sat = rc[DW];
      end
      default: ;
    endcase
  end

  // stage 5: hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
    if (en) begin
      side <= sd5;
      ssq  <= ds4[SSQ_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/qau_sqrt.sv -----
// Pipelined square root rounded to nearest, one root bit per stage.
// Depends on qau_pkg; RB stages plus one rounding stage.
`default_nettype none

module qau_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  qau_pkg::qau_side_t side_in,
  input  logic [qau_pkg::SSQ_W-1:0] ssq_in,
  output logic               out_valid,
  output qau_pkg::qau_side_t side_out,
  output logic [qau_pkg::SSQ_W-1:0] ssq_out,
  output logic [qau_pkg::RB-1:0]    root
);
  import qau_pkg::*;

  logic             v_w   [0:RB];
  qau_side_t        sd_w  [0:RB];
  logic [SSQ_W-1:0] s_w   [0:RB];
  logic [RT_W-1:0]  rem_w [0:RB];
  logic [RT_W-1:0]  res_w [0:RB];

  assign v_w[0]   = in_valid;
  assign sd_w[0]  = side_in;
  assign s_w[0]   = ssq_in;
  assign rem_w[0] = {{(RT_W-SSQ_W){1'b0}}, ssq_in};
  assign res_w[0] = '0;

  for (genvar i = 0; i < RB; i++) begin : g_stage
    localparam logic [RT_W-1:0] BIT = {{(RT_W-1){1'b0}}, 1'b1} << (2 * (RB - 1 - i));
    logic [RT_W-1:0]  trial;
    logic [RT_W-1:0]  rem_next;
    logic [RT_W-1:0]  res_next;
    logic             v;
    qau_side_t        sd;
    logic [SSQ_W-1:0] s;
    logic [RT_W-1:0]  rem;
    logic [RT_W-1:0]  res;

    always_comb begin
      trial = res_w[i] + BIT;
      if (rem_w[i] >= trial) begin
        rem_next = rem_w[i] - trial;
        res_next = (res_w[i] >> 1) + BIT;
      end else begin
        rem_next = rem_w[i];
        res_next = res_w[i] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (en) begin
        v <= v_w[i];
      end
      if (en) begin
        sd  <= sd_w[i];
        s   <= s_w[i];
        rem <= rem_next;
        res <= res_next;
      end
    end

    assign v_w[i+1]   = v;
    assign sd_w[i+1]  = sd;
    assign s_w[i+1]   = s;
    assign rem_w[i+1] = rem;
    assign res_w[i+1] = res;
  end

  // round to nearest: bump when the remainder exceeds the root
  logic [RT_W-1:0] rounded;

  assign rounded = res_w[RB] + {{(RT_W-1){1'b0}}, (rem_w[RB] > res_w[RB])};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_w[RB];
    end
    if (en) begin
      side_out <= sd_w[RB];
      ssq_out  <= s_w[RB];
      root     <= rounded[RB-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/qau_div.sv -----
// Four-lane pipelined restoring divider for normalize and inverse, plus
// the scalar results that come from the root. Depends on qau_pkg.
`default_nettype none

module qau_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  qau_pkg::qau_side_t side_in,
  input  logic [qau_pkg::SSQ_W-1:0] ssq_in,
  input  logic [qau_pkg::RB-1:0]    root_in,
  output logic               out_valid,
  output qau_pkg::qau_side_t side_out,
  output logic [3:0][qau_pkg::QB-1:0] quo,
  output logic [3:0]         ovf
);
  import qau_pkg::*;

  // stage A: build numerator 2N+D and divisor 2D per lane
  qau_side_t              sda_next;
  logic [3:0][NUM_W-1:0]  num_next;
  logic [3:0][DEN_W-1:0]  den_next;
  logic [DW:0]            fm;
  logic                   va;
  qau_side_t              sda;
  logic [3:0][NUM_W-1:0]  num_a;
  logic [3:0][DEN_W-1:0]  den_a;

  always_comb begin
    sda_next = side_in;
    fm       = from_mag(1'b0, {1'b0, root_in});
    for (int n = 0; n < 4; n++) begin
      num_next[n] = '0;
      den_next[n] = {{(DEN_W-1){1'b0}}, 1'b1};
    end
    case (side_in.cmd)
      OP_MAG: begin
        sda_next.sc  = fm[DW-1:0];
        sda_next.sat = fm[DW];
      end
      OP_DIST: begin
        if (side_in.big) begin
          sda_next.sc  = POS_MAX;
          sda_next.sat = 1'b1;
        end else begin
          sda_next.sc  = fm[DW-1:0];
          sda_next.sat = fm[DW];
        end
      end
      OP_NORM: begin
        sda_next.zd = (ssq_in == '0);
        for (int n = 0; n < 4; n++) begin
          num_next[n] = (NUM_W'(side_in.mag[n]) << (FRAC_BITS + 1)) + NUM_W'(root_in);
          den_next[n] = DEN_W'(root_in) << 1;
        end
      end
      OP_INV: begin
        sda_next.zd = (ssq_in == '0);
        for (int n = 0; n < 4; n++) begin
          num_next[n] = (NUM_W'(side_in.mag[n]) << (2 * FRAC_BITS + 1)) + NUM_W'(ssq_in);
          den_next[n] = DEN_W'(ssq_in) << 1;
          if (n != 0) begin
            sda_next.neg[n] = ~side_in.neg[n];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      sda   <= sda_next;
      num_a <= num_next;
      den_a <= den_next;
    end
  end

  // stage B: overflow check, seed the remainder with the high part
  logic [3:0]            ovf_next;
  logic [3:0][DEN_W-1:0] rem_next;
  logic [DEN_W-1:0]      hi;
  logic                  vb;
  qau_side_t             sdb;
  logic [3:0][DEN_W-1:0] rem_b;
  logic [3:0][QB-1:0]    lo_b;
  logic [3:0][DEN_W-1:0] den_b;
  logic [3:0]            ovf_b;

  always_comb begin
    hi = '0;
    for (int n = 0; n < 4; n++) begin
      hi          = DEN_W'(num_a[n][NUM_W-1:QB]);
      ovf_next[n] = (hi >= den_a[n]);
      rem_next[n] = ovf_next[n] ? '0 : hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      sdb   <= sda;
      ovf_b <= ovf_next;
      rem_b <= rem_next;
      den_b <= den_a;
      for (int n = 0; n < 4; n++) begin
        lo_b[n] <= num_a[n][QB-1:0];
      end
    end
  end

  // quotient stages, one bit per lane each
  logic                  v_w   [0:QB];
  qau_side_t             sd_w  [0:QB];
  logic [3:0][DEN_W-1:0] r_w   [0:QB];
  logic [3:0][QB-1:0]    lo_w  [0:QB];
  logic [3:0][DEN_W-1:0] d_w   [0:QB];
  logic [3:0][QB-1:0]    q_w   [0:QB];
  logic [3:0]            o_w   [0:QB];

  assign v_w[0]  = vb;
  assign sd_w[0] = sdb;
  assign r_w[0]  = rem_b;
  assign lo_w[0] = lo_b;
  assign d_w[0]  = den_b;
  assign q_w[0]  = '0;
  assign o_w[0]  = ovf_b;

  for (genvar j = 0; j < QB; j++) begin : g_bit
    logic [DEN_W:0]        rs;
    logic [DEN_W:0]        df;
    logic [3:0][DEN_W-1:0] r_next;
    logic [3:0][QB-1:0]    q_next;
    logic                  v;
    qau_side_t             sd;
    logic [3:0][DEN_W-1:0] r;
    logic [3:0][QB-1:0]    lo;
    logic [3:0][DEN_W-1:0] d;
    logic [3:0][QB-1:0]    q;
    logic [3:0]            o;

    always_comb begin
      rs = '0;
      df = '0;
      for (int n = 0; n < 4; n++) begin
        rs = {r_w[j][n], lo_w[j][n][QB-1-j]};
        df = rs - {1'b0, d_w[j][n]};
        if (rs >= {1'b0, d_w[j][n]}) begin
          r_next[n] = df[DEN_W-1:0];
          q_next[n] = {q_w[j][n][QB-2:0], 1'b1};
        end else begin
          r_next[n] = rs[DEN_W-1:0];
          q_next[n] = {q_w[j][n][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (en) begin
        v <= v_w[j];
      end
      if (en) begin
        sd <= sd_w[j];
        r  <= r_next;
        lo <= lo_w[j];
        d  <= d_w[j];
        q  <= q_next;
        o  <= o_w[j];
      end
    end

    assign v_w[j+1]  = v;
    assign sd_w[j+1] = sd;
    assign r_w[j+1]  = r;
    assign lo_w[j+1] = lo;
    assign d_w[j+1]  = d;
    assign q_w[j+1]  = q;
    assign o_w[j+1]  = o;
  end

  assign out_valid = v_w[QB];
  assign side_out  = sd_w[QB];
  assign quo       = q_w[QB];
  assign ovf       = o_w[QB];

endmodule

`default_nettype wire

// ----- sv/quaternion_arithmetic_unit.sv -----
// Top level of the quaternion unit: front end, square root, divider, output register.
// Depends on qau_pkg, qau_front, qau_sqrt and qau_div.
//
// Usage
//   Input channel op_valid / op_stall / op carries one item: an opcode and two
//   Q16.16 quaternions. Output channel res_valid / res_stall / res returns one
//   result item for every input item, in order. An item moves on a rising edge
//   where valid is high and stall is low.
//   From acceptance to the result standing in the output register an item
//   passes 5 front-end stages (input, operands, products, sums with rounding,
//   hand-over), 33 square-root stages plus one rounding stage, 2 divider set-up
//   stages and 33 quotient stages, then the output register. Every operation
//   takes the same path, so results leave in order.
//   Throughput is one item per cycle while the receiver does not stall; the
//   length is set by the 33-bit root and the 33-bit quotient, one bit per stage each.
//   Reset (rst, synchronous) clears every valid bit; payload registers keep
//   whatever they held. No warm-up is needed after reset.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   op_stall rises in the same cycle; items in flight keep their places and
//   nothing is dropped or repeated. New items are taken whenever the output
//   register is empty or being emptied.
`default_nettype none

module quaternion_arithmetic_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_stall,
  input  qau_pkg::qau_in_t  op,
  output logic              res_valid,
  input  logic              res_stall,
  output qau_pkg::qau_out_t res
);
  import qau_pkg::*;

  // advance every stage unless a finished result is held up
  logic en;

  assign en       = !res_valid || !res_stall;
  assign op_stall = !en;

  logic             f_valid;
  qau_side_t        f_side;
  logic [SSQ_W-1:0] f_ssq;

  qau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (op_valid),
    .in_item   (op),
    .out_valid (f_valid),
    .side      (f_side),
    .ssq       (f_ssq)
  );

  logic             s_valid;
  qau_side_t        s_side;
  logic [SSQ_W-1:0] s_ssq;
  logic [RB-1:0]    s_root;

  qau_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .side_in   (f_side),
    .ssq_in    (f_ssq),
    .out_valid (s_valid),
    .side_out  (s_side),
    .ssq_out   (s_ssq),
    .root      (s_root)
  );

  logic               d_valid;
  qau_side_t          d_side;
  logic [3:0][QB-1:0] d_quo;
  logic [3:0]         d_ovf;

  qau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .side_in   (s_side),
    .ssq_in    (s_ssq),
    .root_in   (s_root),
    .out_valid (d_valid),
    .side_out  (d_side),
    .quo       (d_quo),
    .ovf       (d_ovf)
  );

  // apply signs to the quotients, drop them for a zero quaternion
  qau_out_t           res_next;
  logic [3:0][DW-1:0] rq;
  logic               sat;
  logic [DW:0]        fm;

  always_comb begin
    rq  = d_side.rq;
    sat = d_side.sat;
    fm  = '0;
    if ((d_side.cmd inside {OP_NORM, OP_INV}) && !d_side.zd) begin
      for (int n = 0; n < 4; n++) begin
        fm    = from_mag(d_side.neg[n], {d_ovf[n], d_quo[n]});
        rq[n] = fm[DW-1:0];
        sat   = sat | fm[DW];
      end
    end
    res_next.r_real     = rq[0];
    res_next.r_i        = rq[1];
    res_next.r_j        = rq[2];
    res_next.r_k        = rq[3];
    res_next.scalar_out = d_side.sc;
    res_next.zero_div   = d_side.zd;
    res_next.saturated  = sat;
  end

  // output register: holds the item while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= d_valid;
    end
    if (en) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  // a zero quaternion gives an all-zero, unclipped quaternion
  a_zero_div_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.zero_div |-> res.r_real == 0 && res.r_i == 0 && res.r_j == 0
      && res.r_k == 0 && !res.saturated)
    else $error("zero_div with nonzero quaternion result");

  // scalar and quaternion results never appear together
  a_scalar_alone: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.scalar_out != 0 |-> res.r_real == 0 && res.r_i == 0
      && res.r_j == 0 && res.r_k == 0 && !res.zero_div)
    else $error("scalar result mixed with quaternion result");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire
